@@ rtl/core/ltfd_pkg.sv @@
// ============================================================================
// ltfd_pkg: length/type frame deframer shared definitions
// Widths, header layout constants, operation and result kind codes.
// ============================================================================
`default_nettype none

package ltfd_pkg;

    localparam int LIMIT_W      = 25;
    localparam int LENGTH_W     = 32;
    localparam int BODY_W       = 25;
    localparam int TYPE_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int HDR_CNT_W    = 3;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = 25'd4096;
    localparam logic [HDR_CNT_W-1:0] HEADER_BYTES = 3'd6;
    localparam logic [HDR_CNT_W-1:0] LENGTH_BYTES = 3'd4;
    localparam logic [LENGTH_W-1:0]  TYPE_BYTES   = 32'd2;

    typedef enum logic
    {
        OP_DATA    = 1'b0,
        OP_CONNECT = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed
    {
        logic                valid;
        op_t                 operation;
        logic [BYTE_W-1:0]   data_byte;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/core/ltfd_in_if.sv @@
// ============================================================================
// ltfd_in_if: input byte channel
// Valid/ready channel carrying one stream byte or a new-connection marker.
// ============================================================================
`default_nettype none

interface ltfd_in_if;
    logic                           valid;
    logic                           ready;
    ltfd_pkg::op_t                  operation;
    logic [ltfd_pkg::BYTE_W-1:0]    data_byte;

    modport source
    (
        output valid,
        output operation,
        output data_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  operation,
        input  data_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ltfd_out_if.sv @@
// ============================================================================
// ltfd_out_if: result channel
// Valid/ready channel carrying one deframer result per transfer.
// ============================================================================
`default_nettype none

interface ltfd_out_if;
    logic                           valid;
    logic                           ready;
    ltfd_pkg::kind_t                kind;
    logic [ltfd_pkg::TYPE_W-1:0]    frame_type;
    logic [ltfd_pkg::BYTE_W-1:0]    body_byte;
    logic                           last;

    modport source
    (
        output valid,
        output kind,
        output frame_type,
        output body_byte,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  frame_type,
        input  body_byte,
        input  last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ltfd_in_stage.sv @@
// ============================================================================
// ltfd_in_stage: input register
// Captures one input transfer and holds it until the parser advances.
// ============================================================================
`default_nettype none

module ltfd_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    ltfd_in_if.sink             stream,
    input  wire logic           advance,
    output ltfd_pkg::item_t     item
);

    logic                           valid_reg;
    ltfd_pkg::op_t                  op_reg;
    logic [ltfd_pkg::BYTE_W-1:0]    byte_reg;
    logic                           take;

    assign stream.ready = !valid_reg || advance;
    assign take         = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= stream.operation;
            byte_reg <= stream.data_byte;
        end
    end

    assign item.valid     = valid_reg;
    assign item.operation = op_reg;
    assign item.data_byte = byte_reg;

endmodule

`default_nettype wire

@@ rtl/core/ltfd_parser.sv @@
// ============================================================================
// ltfd_parser: header parser, body tracker and result register
// Updates the header/body state for one item per cycle while the result
// register is free or being taken, and registers any resulting transfer toward the output channel.
// ============================================================================
`default_nettype none

module ltfd_parser
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ltfd_pkg::LIMIT_W-1:0]   limit,
    input  wire ltfd_pkg::item_t                item,
    output logic                                advance,
    ltfd_out_if.source                          result
);

    logic [ltfd_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [ltfd_pkg::LENGTH_W-1:0]  length_reg, length_next;
    logic [ltfd_pkg::TYPE_W-1:0]    type_reg, type_next;
    logic [ltfd_pkg::BODY_W-1:0]    body_reg, body_next;
    logic                           discard_reg, discard_next;

    logic                           out_valid_reg, out_valid_next;
    ltfd_pkg::kind_t                kind_reg, kind_next;
    logic [ltfd_pkg::TYPE_W-1:0]    ftype_reg, ftype_next;
    logic [ltfd_pkg::BYTE_W-1:0]    body_byte_reg, body_byte_next;
    logic                           last_reg, last_next;

    logic                           emit;
    logic [ltfd_pkg::TYPE_W-1:0]    type_shift;
    logic                           len_bad;

    assign advance    = item.valid && (!out_valid_reg || result.ready);
    assign type_shift = {type_reg[ltfd_pkg::BYTE_W-1:0], item.data_byte};
    assign len_bad    = (length_reg < ltfd_pkg::TYPE_BYTES)
                     || (length_reg > {{(ltfd_pkg::LENGTH_W-ltfd_pkg::LIMIT_W){1'b0}}, limit});

    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        length_next    = length_reg;
        type_next      = type_reg;
        body_next      = body_reg;
        discard_next   = discard_reg;
        emit           = 1'b0;
        kind_next      = ltfd_pkg::KIND_BODY;
        ftype_next     = type_reg;
        body_byte_next = '0;
        last_next      = 1'b1;

        if (item.operation == ltfd_pkg::OP_CONNECT)
        begin
            emit         = !discard_reg && (hdr_cnt_reg != '0 || body_reg != '0);
            kind_next    = ltfd_pkg::KIND_ABORT;
            ftype_next   = (body_reg != '0) ? type_reg : '0;
            hdr_cnt_next = '0;
            length_next  = '0;
            type_next    = '0;
            body_next    = '0;
            discard_next = 1'b0;
        end
        else if (discard_reg)
        begin
            emit = 1'b0;
        end
        else if (body_reg != '0)
        begin
            emit           = 1'b1;
            kind_next      = ltfd_pkg::KIND_BODY;
            body_byte_next = item.data_byte;
            last_next      = (body_reg == ltfd_pkg::BODY_W'(1));
            body_next      = body_reg - ltfd_pkg::BODY_W'(1);
        end
        else if (hdr_cnt_reg < ltfd_pkg::LENGTH_BYTES)
        begin
            if (hdr_cnt_reg == '0)
            begin
                length_next = {{(ltfd_pkg::LENGTH_W-ltfd_pkg::BYTE_W){1'b0}}, item.data_byte};
            end
            else
            begin
                length_next = {length_reg[ltfd_pkg::LENGTH_W-ltfd_pkg::BYTE_W-1:0],
                               item.data_byte};
            end
            hdr_cnt_next = hdr_cnt_reg + ltfd_pkg::HDR_CNT_W'(1);
        end
        else if (hdr_cnt_reg + ltfd_pkg::HDR_CNT_W'(1) < ltfd_pkg::HEADER_BYTES)
        begin
            type_next    = type_shift;
            hdr_cnt_next = hdr_cnt_reg + ltfd_pkg::HDR_CNT_W'(1);
        end
        else
        begin
            type_next    = type_shift;
            ftype_next   = type_shift;
            hdr_cnt_next = '0;
            if (len_bad)
            begin
                emit         = 1'b1;
                kind_next    = ltfd_pkg::KIND_ERROR;
                discard_next = 1'b1;
            end
            else if (length_reg == ltfd_pkg::TYPE_BYTES)
            begin
                emit      = 1'b1;
                kind_next = ltfd_pkg::KIND_EMPTY;
            end
            else
            begin
                body_next = ltfd_pkg::BODY_W'(length_reg - ltfd_pkg::TYPE_BYTES);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            length_reg    <= '0;
            type_reg      <= '0;
            body_reg      <= '0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                hdr_cnt_reg <= hdr_cnt_next;
                length_reg  <= length_next;
                type_reg    <= type_next;
                body_reg    <= body_next;
                discard_reg <= discard_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg      <= kind_next;
            ftype_reg     <= ftype_next;
            body_byte_reg <= body_byte_next;
            last_reg      <= last_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = kind_reg;
    assign result.frame_type = ftype_reg;
    assign result.body_byte  = body_byte_reg;
    assign result.last       = last_reg;

`ifndef NO_ASSERTIONS
    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg < ltfd_pkg::HEADER_BYTES)
        else $error("header count out of range");

    a_body_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        body_reg != '0 |-> hdr_cnt_reg == '0 && !discard_reg)
        else $error("body in progress with header or discard active");

    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> hdr_cnt_reg == '0 && body_reg == '0)
        else $error("discard with parser state pending");

    a_non_body_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != ltfd_pkg::KIND_BODY |-> last_reg && body_byte_reg == '0)
        else $error("non-body result not marked last");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(kind_reg)
                                          && $stable(body_byte_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/length_type_frame_deframer_unit.sv @@
// ============================================================================
// length_type_frame_deframer_unit: length/type frame deframer top level
// Splits a byte stream into frames of a 4-byte length, 2-byte type and body,
// emitting body bytes tagged with the type, plus empty/error/abort results.
// ============================================================================
//
//  channel   dir  handshake        payload
//  stream    in   valid/ready      operation, data_byte
//  result    out  valid/ready      kind, frame_type, body_byte, last
//  limit     in   write enable     limit_write_data (25 bits)
//
//  One item per cycle sustained while result.ready holds; an item is first
//  held in the input register, then its result in the result register.
//  rst_n clears parser state and sets the length limit to 4096.
//  A stalled result holds the result register; the input register still
//  takes one more item, after which stream.ready follows result.ready.
//
`default_nettype none

module length_type_frame_deframer_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           limit_write_enable,
    input  wire logic [ltfd_pkg::LIMIT_W-1:0]   limit_write_data,
    ltfd_in_if.sink                             stream,
    ltfd_out_if.source                          result
);

    logic [ltfd_pkg::LIMIT_W-1:0]   limit_reg;
    ltfd_pkg::item_t                item;
    logic                           advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ltfd_pkg::LIMIT_RESET;
        end
        else if (limit_write_enable)
        begin
            limit_reg <= limit_write_data;
        end
    end

    ltfd_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .advance (advance),
        .item    (item)
    );

    ltfd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit_reg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ sim/tb_length_type_frame_deframer_unit.sv @@
// ============================================================================
// tb_length_type_frame_deframer_unit: self-checking bench for the deframer
// Drives framed byte streams with connection resets through the stream
// channel. It predicts each result from a cycle-free deframer model and
// checks the result channel in order. Random gaps, stalls and one long
// result hold-off are applied at several length limits.
// ============================================================================
`default_nettype none

module tb_length_type_frame_deframer_unit;
    import ltfd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct
    {
        op_t                operation;
        logic [BYTE_W-1:0]  data_byte;
    } stream_item_t;

    typedef struct
    {
        kind_t              kind;
        logic [TYPE_W-1:0]  frame_type;
        logic [BYTE_W-1:0]  body_byte;
        logic               last;
    } frame_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               limit_write_enable;
    logic [LIMIT_W-1:0] limit_write_data;

    ltfd_in_if  stream_if();
    ltfd_out_if result_if();

    length_type_frame_deframer_unit dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .limit_write_enable (limit_write_enable),
        .limit_write_data   (limit_write_data),
        .stream             (stream_if),
        .result             (result_if)
    );

    stream_item_t  stream_backlog[$];
    frame_result_t expected_frame_results[$];
    int unsigned   items_queued   = 0;
    int unsigned   send_gap_pct   = 0;
    int unsigned   recv_stall_pct = 0;
    logic          hold_armed     = 1'b0;
    logic          hold_done      = 1'b0;
    int unsigned   hold_left      = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles   = 0;

    // deframer model state
    logic [LIMIT_W-1:0]   limit_model = LIMIT_RESET;
    logic [HDR_CNT_W-1:0] hdr_seen    = '0;
    logic [LENGTH_W-1:0]  length_acc  = '0;
    logic [TYPE_W-1:0]    type_acc    = '0;
    logic [LENGTH_W-1:0]  body_left   = '0;
    logic                 discarding  = 1'b0;

    always #CLK_HALF clk = ~clk;

    task automatic expect_frame_result(input kind_t k, input logic [TYPE_W-1:0] t,
                                       input logic [BYTE_W-1:0] b, input logic l);
        frame_result_t r;
        r.kind       = k;
        r.frame_type = t;
        r.body_byte  = b;
        r.last       = l;
        expected_frame_results.push_back(r);
    endtask

    task automatic deframe_step(input op_t op, input logic [BYTE_W-1:0] b);
        logic              mid;
        logic [TYPE_W-1:0] abort_type;
        if (op == OP_CONNECT)
        begin
            mid        = !discarding && (hdr_seen != '0 || body_left != '0);
            abort_type = (body_left != '0) ? type_acc : '0;
            hdr_seen   = '0;
            length_acc = '0;
            type_acc   = '0;
            body_left  = '0;
            discarding = 1'b0;
            if (mid)
                expect_frame_result(KIND_ABORT, abort_type, '0, 1'b1);
        end
        else if (!discarding)
        begin
            if (body_left != '0)
            begin
                expect_frame_result(KIND_BODY, type_acc, b, body_left == 1);
                body_left = body_left - 1;
            end
            else if (hdr_seen < LENGTH_BYTES)
            begin
                if (hdr_seen == '0)
                begin
                    length_acc = '0;
                    type_acc   = '0;
                end
                length_acc = {length_acc[LENGTH_W-BYTE_W-1:0], b};
                hdr_seen   = hdr_seen + 1'b1;
            end
            else
            begin
                type_acc = {type_acc[TYPE_W-BYTE_W-1:0], b};
                hdr_seen = hdr_seen + 1'b1;
                if (hdr_seen == HEADER_BYTES)
                begin
                    hdr_seen = '0;
                    if (length_acc < TYPE_BYTES || length_acc > limit_model)
                    begin
                        discarding = 1'b1;
                        expect_frame_result(KIND_ERROR, type_acc, '0, 1'b1);
                    end
                    else if (length_acc == TYPE_BYTES)
                        expect_frame_result(KIND_EMPTY, type_acc, '0, 1'b1);
                    else
                        body_left = length_acc - TYPE_BYTES;
                end
            end
        end
    endtask

    task automatic check_frame_result();
        frame_result_t got;
        frame_result_t want;
        got.kind       = result_if.kind;
        got.frame_type = result_if.frame_type;
        got.body_byte  = result_if.body_byte;
        got.last       = result_if.last;
        if (expected_frame_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: kind %0d type %h byte %h last %b",
                         got.kind, got.frame_type, got.body_byte, got.last);
        end
        else
        begin
            want = expected_frame_results.pop_front();
            if (got.kind !== want.kind || got.frame_type !== want.frame_type ||
                got.body_byte !== want.body_byte || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("result mismatch: exp kind %0d type %h byte %h last %b",
                             want.kind, want.frame_type, want.body_byte, want.last);
                    $display("                 got kind %0d type %h byte %h last %b",
                             got.kind, got.frame_type, got.body_byte, got.last);
                end
            end
        end
    endtask

    task automatic push_item(input op_t op, input logic [BYTE_W-1:0] b);
        stream_item_t it;
        it.operation = op;
        it.data_byte = b;
        stream_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic push_data(input logic [BYTE_W-1:0] b);
        push_item(OP_DATA, b);
    endtask

    task automatic push_connect();
        push_item(OP_CONNECT, 8'($urandom));
    endtask

    task automatic push_header(input logic [LENGTH_W-1:0] len, input logic [TYPE_W-1:0] ftype);
        for (int i = 3; i >= 0; i--)
            push_data(len[8*i +: 8]);
        push_data(ftype[15:8]);
        push_data(ftype[7:0]);
    endtask

    task automatic queue_random_traffic(input int unsigned count, input logic [31:0] limit);
        int unsigned   stop_at;
        int unsigned   pick;
        int unsigned   span;
        int unsigned   body;
        int unsigned   cut;
        logic [31:0]   len;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                span = (limit >= 12) ? 10 : ((limit >= 2) ? limit - 2 : 0);
                len  = 2 + $urandom_range(0, span);
                body = len - 2;
                cut  = body;
                if (body != 0 && $urandom_range(0, 9) == 0)
                    cut = $urandom_range(0, body - 1);
                push_header(len, 16'($urandom));
                repeat (cut) push_data(8'($urandom));
                if (cut != body || len > limit)
                    push_connect();
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 3))
                    0: len = 32'd0;
                    1: len = 32'd1;
                    2: len = limit + 1;
                    default:
                    begin
                        len = $urandom;
                        if (len <= limit)
                            len[31] = 1'b1;
                    end
                endcase
                push_header(len, 16'($urandom));
                repeat ($urandom_range(0, 3)) push_data(8'($urandom));
                push_connect();
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(1, 5)) push_data(8'($urandom));
                push_connect();
            end
            else if (pick < 93)
                push_connect();
            else
            begin
                // garbage header, may open a long body
                repeat ($urandom_range(6, 12)) push_data(8'($urandom));
                push_connect();
            end
        end
    endtask

    task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        limit_write_enable <= 1'b1;
        limit_write_data   <= value;
        @(posedge clk);
        limit_write_enable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_backlog.size() != 0 || stream_if.valid ||
               expected_frame_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : drive_stream
        stream_item_t next_item;
        if (!rst_n)
            stream_if.valid <= 1'b0;
        else if (!stream_if.valid || stream_if.ready)
        begin
            if (stream_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                next_item = stream_backlog.pop_front();
                stream_if.valid     <= 1'b1;
                stream_if.operation <= next_item.operation;
                stream_if.data_byte <= next_item.data_byte;
            end
            else
                stream_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one long result hold-off while the stream keeps offering
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done && stream_if.valid)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (limit_write_enable)
                limit_model = limit_write_data;
            if (stream_if.valid && stream_if.ready)
                deframe_step(stream_if.operation, stream_if.data_byte);
            if (result_if.valid && result_if.ready)
                check_frame_result();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((stream_if.valid && stream_if.ready) ||
                (result_if.valid && result_if.ready) || limit_write_enable)
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("tb_length_type_frame_deframer_unit: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        limit_write_enable  = 1'b0;
        limit_write_data    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limit
        send_gap_pct   = 21;
        recv_stall_pct = 60;
        push_connect();
        push_header(32'd2, 16'hFFFF);
        push_header(32'd3, 16'h0000);
        push_data(8'hFF);
        push_header(32'd1, 16'hA55A);
        push_data(8'h00);
        push_connect();
        push_data(8'h12);
        push_data(8'h34);
        push_data(8'h56);
        push_connect();
        queue_random_traffic(130, 32'd4096);
        wait_drained();

        // lowest legal limit: only empty frames pass
        write_frame_limit(25'd2);
        push_header(32'd0, 16'h1234);
        push_connect();
        push_header(32'd2, 16'h5678);
        push_header(32'd3, 16'h9ABC);
        push_connect();
        queue_random_traffic(20, 32'd2);
        wait_drained();

        // limit below two rejects everything
        write_frame_limit(25'd0);
        push_header(32'd2, 16'h00FF);
        push_data(8'hAA);
        push_connect();
        wait_drained();

        send_gap_pct   = 60;
        recv_stall_pct = 21;
        write_frame_limit(25'd16777216);
        push_header(32'h0100_0001, 16'h8001);
        push_connect();
        push_header(32'hFFFF_FFFF, 16'h7FFE);
        push_connect();
        push_header(32'h0100_0000, 16'hC3C3);
        push_data(8'h01);
        push_data(8'h80);
        push_data(8'h7F);
        push_connect();
        queue_random_traffic(130, 32'd16777216);
        wait_drained();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_frame_limit(25'd7);
        hold_armed = 1'b1;
        push_header(32'd7, 16'h0F0F);
        repeat (5) push_data(8'($urandom));
        push_header(32'd8, 16'hF0F0);
        push_connect();
        queue_random_traffic(150, 32'd7);
        wait_drained();

        if (mismatch_count == 0 && expected_frame_results.size() == 0)
            $display("tb_length_type_frame_deframer_unit: PASS");
        else
            $display("tb_length_type_frame_deframer_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/ltfd_pkg.sv
rtl/core/ltfd_in_if.sv
rtl/core/ltfd_out_if.sv
rtl/core/ltfd_in_stage.sv
rtl/core/ltfd_parser.sv
rtl/core/length_type_frame_deframer_unit.sv
sim/tb_length_type_frame_deframer_unit.sv
